### hdl/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types, constants and table functions for the deviation histogram.
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int SUPER_BIN_COUNT    = 19;
  localparam int MAX_BINS_PER_SUPER = 50;
  localparam int COUNTER_WIDTH      = 32;

  localparam int TOTAL_W   = 40;
  localparam int DIST_W    = TOTAL_W + 2;
  localparam int SUPER_W   = 5;
  localparam int BIN_W     = 6;
  localparam int COUNT_W   = 32;
  localparam int STEP_W    = 3;
  localparam int SQ_W      = 2 * BIN_W;
  localparam int PROD_W    = SQ_W + TOTAL_W;
  localparam int DSQ_W     = 64;

  // bins ahead of the first full-size super bin: 1 + 2 + 2 + 8 + 32
  localparam int SMALL_BINS  = 45;
  localparam int STORE_DEPTH = SMALL_BINS + MAX_BINS_PER_SUPER * (SUPER_BIN_COUNT - 5);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic CMD_HIT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic               command;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] hit_count;
    logic [SUPER_W-1:0] read_super_bin;
    logic [BIN_W-1:0]   read_bin;
  } bdh_in_t;

  typedef struct packed {
    logic [SUPER_W-1:0] super_bin;
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
    logic               bad_request;
  } bdh_out_t;

  // request into the bin search unit
  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] n;
    logic [TOTAL_W-1:0] m;
    logic [BIN_W-1:0]   last;
  } bdh_srch_req_t;

  // answer from the bin search unit
  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] k;
  } bdh_srch_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_READ,
    ST_MODIFY
  } bdh_state_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_SQUARE,
    SR_STEP
  } bdh_srch_state_t;

  // super bin selected by a total
  function automatic logic [SUPER_W-1:0] super_of(input logic [TOTAL_W-1:0] n);
    logic [SUPER_W-1:0] res;
    res = SUPER_W'(18);
    for (int s = 17; s >= 4; s--) begin
      if ({24'd0, n} < (64'd1 << (2 * s - 2))) res = SUPER_W'(s);
    end
    if (n < TOTAL_W'(16)) res = SUPER_W'(3);
    if (n == TOTAL_W'(3)) res = SUPER_W'(2);
    if (n == TOTAL_W'(2)) res = SUPER_W'(1);
    if (n == TOTAL_W'(1)) res = SUPER_W'(0);
    return res;
  endfunction

  // number of bins in a super bin
  function automatic logic [BIN_W:0] bins_in(input logic [SUPER_W-1:0] s);
    logic [BIN_W:0] res;
    case (s)
      SUPER_W'(0): res = (BIN_W+1)'(1);
      SUPER_W'(1): res = (BIN_W+1)'(2);
      SUPER_W'(2): res = (BIN_W+1)'(2);
      SUPER_W'(3): res = (BIN_W+1)'(8);
      SUPER_W'(4): res = (BIN_W+1)'(32);
      default:     res = (BIN_W+1)'(MAX_BINS_PER_SUPER);
    endcase
    return res;
  endfunction

  // first store address of a super bin
  function automatic logic [ADDR_W-1:0] base_of(input logic [SUPER_W-1:0] s);
    logic [ADDR_W-1:0] res;
    case (s)
      SUPER_W'(0): res = ADDR_W'(0);
      SUPER_W'(1): res = ADDR_W'(1);
      SUPER_W'(2): res = ADDR_W'(3);
      SUPER_W'(3): res = ADDR_W'(5);
      SUPER_W'(4): res = ADDR_W'(13);
      default:     res = ADDR_W'(SMALL_BINS + MAX_BINS_PER_SUPER * (int'(s) - 5));
    endcase
    return res;
  endfunction

endpackage

### hdl/binomial_deviation_histogram_unit.sv
// ----------------------------------------------------------------------------
// binomial_deviation_histogram_unit
// Counts hits per deviation bin in one counter RAM and reads counters back.
// ----------------------------------------------------------------------------
// Sequence: a hit passes PREP, CALC (bin search loop), READ and MODIFY, and a read
// passes PREP, READ and MODIFY; the result goes to the output register in MODIFY.
// One item is taken at a time, and MODIFY waits while a stalled result is held.
// The next item is taken while a result still waits at the output register.
// Reset: synchronous, active low; a clearing pass then zeroes the 745 counters
// in turn, with input stalled.
module binomial_deviation_histogram_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdh_pkg::bdh_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bdh_pkg::bdh_out_t out_data
);

  bdh_pkg::bdh_state_t state_r, state_nxt;

  logic [bdh_pkg::ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bdh_pkg::bdh_out_t                 out_data_r, out_data_nxt;

  logic                              cmd_r, cmd_nxt;
  logic [bdh_pkg::TOTAL_W-1:0]       n_r, n_nxt;
  logic [bdh_pkg::TOTAL_W-1:0]       m_r, m_nxt;
  logic [bdh_pkg::SUPER_W-1:0]       s_r, s_nxt;
  logic [bdh_pkg::BIN_W-1:0]         k_r, k_nxt;
  logic                              bad_r, bad_nxt;
  logic [bdh_pkg::ADDR_W-1:0]        addr_r, addr_nxt;

  logic [bdh_pkg::SUPER_W-1:0]       hit_super;
  logic [bdh_pkg::BIN_W:0]           hit_bins;
  logic                              read_ok;
  logic [bdh_pkg::ADDR_W-1:0]        entry_addr;
  logic [bdh_pkg::COUNTER_WIDTH-1:0] inc_val;

  logic                              ram_we;
  logic [bdh_pkg::ADDR_W-1:0]        ram_waddr;
  logic [bdh_pkg::COUNTER_WIDTH-1:0] ram_wdata;
  logic [bdh_pkg::COUNTER_WIDTH-1:0] ram_rdata;

  bdh_pkg::bdh_srch_req_t            srch_req;
  bdh_pkg::bdh_srch_rsp_t            srch_rsp;

  // counter store
  bdh_ram #(
    .WIDTH (bdh_pkg::COUNTER_WIDTH),
    .DEPTH (bdh_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (entry_addr),
    .rdata (ram_rdata)
  );

  // bin search unit
  bdh_bin_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (srch_req),
    .rsp   (srch_rsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdh_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    s_r        <= s_nxt;
    k_r        <= k_nxt;
    bad_r      <= bad_nxt;
    addr_r     <= addr_nxt;
  end

  // super bin and range checks
  always_comb begin
    hit_super  = bdh_pkg::super_of(n_r);
    hit_bins   = bdh_pkg::bins_in(hit_super);
    read_ok    = (s_r < bdh_pkg::SUPER_W'(bdh_pkg::SUPER_BIN_COUNT))
              && ({1'b0, k_r} < bdh_pkg::bins_in(s_r));
    entry_addr = bdh_pkg::base_of(s_r) + bdh_pkg::ADDR_W'(k_r);
    inc_val    = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
  end

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    k_nxt         = k_r;
    bad_nxt       = bad_r;
    addr_nxt      = addr_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = inc_val;
    srch_req      = '0;
    in_stall      = 1'b1;

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bdh_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == bdh_pkg::ADDR_W'(bdh_pkg::STORE_DEPTH - 1)) begin
          state_nxt = bdh_pkg::ST_IDLE;
        end
      end
      bdh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          n_nxt     = in_data.hit_total;
          m_nxt     = in_data.hit_count;
          s_nxt     = in_data.read_super_bin;
          k_nxt     = in_data.read_bin;
          state_nxt = bdh_pkg::ST_PREP;
        end
      end
      bdh_pkg::ST_PREP: begin
        if (cmd_r == bdh_pkg::CMD_HIT) begin
          s_nxt          = hit_super;
          bad_nxt        = (n_r == '0);
          srch_req.start = 1'b1;
          srch_req.n     = n_r;
          srch_req.m     = m_r;
          srch_req.last  = bdh_pkg::BIN_W'(hit_bins - 1'b1);
          state_nxt      = bdh_pkg::ST_CALC;
        end else begin
          bad_nxt   = !read_ok;
          state_nxt = bdh_pkg::ST_READ;
        end
      end
      bdh_pkg::ST_CALC: begin
        if (srch_rsp.done) begin
          k_nxt     = srch_rsp.k;
          state_nxt = bdh_pkg::ST_READ;
        end
      end
      bdh_pkg::ST_READ: begin
        // read address goes to the RAM this cycle
        addr_nxt  = entry_addr;
        state_nxt = bdh_pkg::ST_MODIFY;
      end
      bdh_pkg::ST_MODIFY: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.super_bin   = s_r;
          out_data_nxt.bin         = k_r;
          out_data_nxt.bad_request = bad_r;
          if (cmd_r == bdh_pkg::CMD_HIT) begin
            ram_we             = 1'b1;
            out_data_nxt.count = bdh_pkg::COUNT_W'(inc_val);
          end else if (bad_r) begin
            out_data_nxt.count = '0;
          end else begin
            out_data_nxt.count = bdh_pkg::COUNT_W'(ram_rdata);
          end
          state_nxt = bdh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bdh_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/bdh_ram.sv
// ----------------------------------------------------------------------------
// bdh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 745
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/bdh_bin_search.sv
// ----------------------------------------------------------------------------
// bdh_bin_search
// Finds the largest k <= last with k*k*n <= d*d, d = |2m - n|, one bit a cycle.
// ----------------------------------------------------------------------------
module bdh_bin_search (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bdh_pkg::bdh_srch_req_t req,
  output bdh_pkg::bdh_srch_rsp_t rsp
);

  bdh_pkg::bdh_srch_state_t state_r, state_nxt;

  logic [bdh_pkg::TOTAL_W-1:0] n_r, n_nxt;
  logic [bdh_pkg::DIST_W-1:0]  d_r, d_nxt;
  logic [bdh_pkg::DSQ_W-1:0]   dd_r, dd_nxt;
  logic                        big_r, big_nxt;
  logic                        zero_r, zero_nxt;
  logic [bdh_pkg::BIN_W-1:0]   last_r, last_nxt;
  logic [bdh_pkg::BIN_W-1:0]   k_r, k_nxt;
  logic [bdh_pkg::SQ_W-1:0]    ksq_r, ksq_nxt;
  logic [bdh_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        done_r, done_nxt;

  logic [bdh_pkg::DIST_W-1:0]  twom;
  logic [bdh_pkg::DIST_W-1:0]  n_ext;
  logic [31:0]                 d_lo;
  logic [bdh_pkg::BIN_W-1:0]   trial;
  logic [bdh_pkg::SQ_W-1:0]    trial_sq;
  logic [bdh_pkg::PROD_W-1:0]  prod;
  logic                        fits;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdh_pkg::SR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    dd_r   <= dd_nxt;
    big_r  <= big_nxt;
    zero_r <= zero_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    ksq_r  <= ksq_nxt;
    step_r <= step_nxt;
  end

  // trial of one bit: (k + 2^b)^2 = k^2 + k*2^(b+1) + 2^(2b)
  always_comb begin
    twom     = {1'b0, req.m, 1'b0};
    n_ext    = {2'b00, req.n};
    d_lo     = d_r[31:0];
    trial    = k_r | (bdh_pkg::BIN_W'(1) << step_r);
    trial_sq = ksq_r + (bdh_pkg::SQ_W'(k_r) << (step_r + 3'd1))
             + (bdh_pkg::SQ_W'(1) << ({1'b0, step_r} << 1));
    prod     = bdh_pkg::PROD_W'(trial_sq) * bdh_pkg::PROD_W'(n_r);
    fits     = (trial <= last_r)
             && (big_r || ({12'd0, prod} <= dd_r));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    dd_nxt    = dd_r;
    big_nxt   = big_r;
    zero_nxt  = zero_r;
    last_nxt  = last_r;
    k_nxt     = k_r;
    ksq_nxt   = ksq_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      bdh_pkg::SR_IDLE: begin
        if (req.start) begin
          n_nxt     = req.n;
          d_nxt     = (twom >= n_ext) ? (twom - n_ext) : (n_ext - twom);
          zero_nxt  = (req.n == '0);
          last_nxt  = req.last;
          state_nxt = bdh_pkg::SR_SQUARE;
        end
      end
      bdh_pkg::SR_SQUARE: begin
        dd_nxt    = bdh_pkg::DSQ_W'(d_lo) * bdh_pkg::DSQ_W'(d_lo);
        big_nxt   = |d_r[bdh_pkg::DIST_W-1:32];
        k_nxt     = '0;
        ksq_nxt   = '0;
        step_nxt  = bdh_pkg::STEP_W'(bdh_pkg::BIN_W - 1);
        state_nxt = bdh_pkg::SR_STEP;
      end
      bdh_pkg::SR_STEP: begin
        if (fits) begin
          k_nxt   = trial;
          ksq_nxt = trial_sq;
        end
        step_nxt = step_r - 3'd1;
        if (step_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = bdh_pkg::SR_IDLE;
        end
      end
      default: state_nxt = bdh_pkg::SR_IDLE;
    endcase
  end

  // zero total goes to the last bin
  assign rsp.done = done_r;
  assign rsp.k    = zero_r ? last_r : k_r;

endmodule

### hdl/bdh_checker.sv
// ----------------------------------------------------------------------------
// bdh_checker
// Port-level checks on the histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input bdh_pkg::bdh_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the clearing pass keeps the input stalled after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a good result always has a super bin below 19 and a bin below 50
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_request |->
      (out_data.super_bin < 5'd19) && (out_data.bin < 6'd50))
    else $error("result index out of range");

endmodule

bind binomial_deviation_histogram_unit bdh_checker u_bdh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
